// ----- rtl/core/kps_pkg.sv -----
// Shared types, constants and codes of the pose smoother.
package kps_pkg;

  localparam int unsigned AXES     = 6;
  localparam int unsigned DataW    = 32;
  localparam int unsigned NoiseW   = 31;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam int unsigned MulAW    = DataW + 1;
  localparam int unsigned MulBW    = DataW;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned FracW    = 31;

  localparam logic [DataW-1:0]  Q31One        = 32'h8000_0000;
  localparam logic [DataW-1:0]  EstMax        = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0]  EstMin        = 32'h8000_0000;
  localparam logic [NoiseW-1:0] ProcNoiseRst  = 31'd21475;
  localparam logic [NoiseW-1:0] MeasNoiseRst  = 31'd21474836;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROCESS_NOISE = 4'd0,
    CFG_MEAS_NOISE    = 4'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    LANE_IDLE,
    LANE_PREP,
    LANE_DIV,
    LANE_MULC,
    LANE_MULV,
    LANE_FIN,
    LANE_DONE
  } lane_state_e;

  typedef struct packed {
    logic signed [DataW-1:0] meas_x;
    logic signed [DataW-1:0] meas_y;
    logic signed [DataW-1:0] meas_z;
    logic signed [DataW-1:0] meas_roll;
    logic signed [DataW-1:0] meas_pitch;
    logic signed [DataW-1:0] meas_yaw;
  } meas_t;

  typedef struct packed {
    logic signed [DataW-1:0] est_x;
    logic signed [DataW-1:0] est_y;
    logic signed [DataW-1:0] est_z;
    logic signed [DataW-1:0] est_roll;
    logic signed [DataW-1:0] est_pitch;
    logic signed [DataW-1:0] est_yaw;
  } est_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [DataW-1:0]   value;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] est;
  } lane_stat_t;

endpackage

// ----- rtl/core/kps_stream_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
interface kps_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/kps_lane.sv -----
// One axis of the filter: state, bit-serial gain divider and shared multiplier.
module kps_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kps_pkg::lane_ctrl_t            ctrl_i,
  input  logic [kps_pkg::DataW-1:0]      meas_i,
  input  logic [kps_pkg::NoiseW-1:0]     q_i,
  input  logic [kps_pkg::NoiseW-1:0]     r_i,
  output kps_pkg::lane_stat_t            stat_o
);

  localparam logic [kps_pkg::CntW-1:0] CntTop = kps_pkg::CntW'(kps_pkg::DivSteps - 1);

  kps_pkg::lane_state_e state_q, state_d;

  logic [kps_pkg::DataW-1:0]  est_q, est_d;
  logic [kps_pkg::DataW-1:0]  var_q, var_d;
  logic [kps_pkg::DataW-1:0]  z_q, z_d;
  logic [kps_pkg::DataW-1:0]  pp_q, pp_d;
  logic [kps_pkg::DataW:0]    den_q, den_d;
  logic [kps_pkg::DataW:0]    rem_q, rem_d;
  logic [kps_pkg::DataW-1:0]  gain_q, gain_d;
  logic [kps_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       neg_q, neg_d;
  logic [kps_pkg::DataW:0]    mag_q, mag_d;
  logic [kps_pkg::ProdW-1:0]  prod_q, prod_d;

  logic [kps_pkg::DataW:0]    pp_sum;
  logic [kps_pkg::DataW:0]    diff;
  logic [kps_pkg::DataW+1:0]  trial;
  logic [kps_pkg::DataW+1:0]  trial_sub;
  logic                       take;
  logic [kps_pkg::MulAW-1:0]  mul_a;
  logic [kps_pkg::MulBW-1:0]  mul_b;
  logic [kps_pkg::ProdW-1:0]  mul_p;
  logic [kps_pkg::DataW+1:0]  corr;
  logic [kps_pkg::DataW+2:0]  est_ext;
  logic [kps_pkg::DataW+2:0]  est_sum;

  assign pp_sum    = {1'b0, var_q} + {2'b00, q_i};
  assign diff      = {z_q[kps_pkg::DataW-1], z_q} - {est_q[kps_pkg::DataW-1], est_q};
  assign trial     = {rem_q, (cnt_q == CntTop) & pp_q[0]};
  assign trial_sub = trial - {1'b0, den_q};
  assign take      = (trial >= {1'b0, den_q}) && (den_q != '0);
  assign mul_p     = mul_a * mul_b;
  assign corr      = prod_q[kps_pkg::ProdW-1:kps_pkg::FracW];
  assign est_ext   = {{3{est_q[kps_pkg::DataW-1]}}, est_q};
  assign est_sum   = neg_q ? est_ext - {1'b0, corr} : est_ext + {1'b0, corr};

  always_comb begin
    state_d = state_q;
    case (state_q)
      kps_pkg::LANE_IDLE: begin
        if (ctrl_i.start) begin
          state_d = kps_pkg::LANE_PREP;
        end
      end
      kps_pkg::LANE_PREP: state_d = kps_pkg::LANE_DIV;
      kps_pkg::LANE_DIV: begin
        if (cnt_q == '0) begin
          state_d = kps_pkg::LANE_MULC;
        end
      end
      kps_pkg::LANE_MULC: state_d = kps_pkg::LANE_MULV;
      kps_pkg::LANE_MULV: state_d = kps_pkg::LANE_FIN;
      kps_pkg::LANE_FIN:  state_d = kps_pkg::LANE_DONE;
      kps_pkg::LANE_DONE: begin
        if (ctrl_i.ack) begin
          state_d = kps_pkg::LANE_IDLE;
        end
      end
      default: state_d = kps_pkg::LANE_IDLE;
    endcase
  end

  always_comb begin
    est_d  = est_q;
    var_d  = var_q;
    z_d    = z_q;
    pp_d   = pp_q;
    den_d  = den_q;
    rem_d  = rem_q;
    gain_d = gain_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    prod_d = prod_q;
    mul_a  = mag_q;
    mul_b  = gain_q;
    case (state_q)
      kps_pkg::LANE_IDLE: begin
        if (ctrl_i.start) begin
          z_d  = meas_i;
          pp_d = pp_sum[kps_pkg::DataW] ? '1 : pp_sum[kps_pkg::DataW-1:0];
        end
      end
      kps_pkg::LANE_PREP: begin
        den_d  = {1'b0, pp_q} + {2'b00, r_i};
        rem_d  = {2'b00, pp_q[kps_pkg::DataW-1:1]};
        gain_d = '0;
        cnt_d  = CntTop;
        neg_d  = diff[kps_pkg::DataW];
        mag_d  = diff[kps_pkg::DataW] ? -diff : diff;
      end
      kps_pkg::LANE_DIV: begin
        rem_d  = take ? trial_sub[kps_pkg::DataW:0] : trial[kps_pkg::DataW:0];
        gain_d = {gain_q[kps_pkg::DataW-2:0], take};
        cnt_d  = cnt_q - 1'b1;
      end
      kps_pkg::LANE_MULC: begin
        prod_d = mul_p;
      end
      kps_pkg::LANE_MULV: begin
        mul_a = {1'b0, kps_pkg::Q31One - gain_q};
        mul_b = pp_q;
        prod_d = mul_p;
        if (est_sum[kps_pkg::DataW+2:kps_pkg::DataW-1] != '0 &&
            est_sum[kps_pkg::DataW+2:kps_pkg::DataW-1] != '1) begin
          est_d = est_sum[kps_pkg::DataW+2] ? kps_pkg::EstMin : kps_pkg::EstMax;
        end else begin
          est_d = est_sum[kps_pkg::DataW-1:0];
        end
      end
      kps_pkg::LANE_FIN: begin
        var_d = prod_q[kps_pkg::FracW+kps_pkg::DataW-1:kps_pkg::FracW];
      end
      kps_pkg::LANE_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kps_pkg::LANE_IDLE;
      est_q   <= '0;
      var_q   <= kps_pkg::Q31One;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      var_q   <= var_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    pp_q   <= pp_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    gain_q <= gain_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
  end

  assign stat_o.done = (state_q == kps_pkg::LANE_DONE);
  assign stat_o.est  = est_q;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> state_q == kps_pkg::LANE_IDLE)
    else $error("lane started while busy");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kps_pkg::LANE_DIV && cnt_q == '0) |=> state_q == kps_pkg::LANE_MULC)
    else $error("divider did not finish after last step");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kps_pkg::LANE_MULC |-> gain_q <= kps_pkg::Q31One)
    else $error("gain above one");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kps_pkg::LANE_MULC && den_q == '0) |-> gain_q == '0)
    else $error("gain nonzero with zero denominator");
`endif

endmodule

// ----- rtl/core/kps_merge.sv -----
// Output register that gathers the lane estimates into one result item.
module kps_merge (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  kps_pkg::lane_stat_t [kps_pkg::AXES-1:0] stat_i,
  output logic                                    ack_o,
  kps_stream_if.source                            est_o
);

  logic          valid_q, valid_d;
  kps_pkg::est_t out_q, out_d;
  logic          all_done;
  logic [kps_pkg::AXES-1:0] done_vec;

  always_comb begin
    for (int unsigned a = 0; a < kps_pkg::AXES; a++) begin
      done_vec[a] = stat_i[a].done;
    end
  end

  assign all_done = &done_vec;
  assign ack_o    = all_done && (!valid_q || est_o.ready);

  always_comb begin
    valid_d = valid_q;
    out_d   = out_q;
    if (ack_o) begin
      valid_d         = 1'b1;
      out_d.est_x     = stat_i[0].est;
      out_d.est_y     = stat_i[1].est;
      out_d.est_z     = stat_i[2].est;
      out_d.est_roll  = stat_i[3].est;
      out_d.est_pitch = stat_i[4].est;
      out_d.est_yaw   = stat_i[5].est;
    end else if (est_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign est_o.valid = valid_q;
  assign est_o.data  = out_q;

endmodule

// ----- rtl/core/kalman_pose_smoother_unit.sv -----
// Top level of the six-axis pose smoother: config registers, lanes and merge.
//
//   channel  dir  handshake     payload
//   meas_i   in   valid/ready   meas_x .. meas_yaw, signed Q16.16
//   est_o    out  valid/ready   est_x .. est_yaw, signed Q16.16
//   cfg_i    in   valid/ready   index, value (process and measurement noise)
//
// An item passes from acceptance to a valid result through the
// 32-step gain divider in each lane plus prep, two multiplies, writeback and output load.
// The next item is accepted once the result has moved into the output register,
// so a new item is never taken while the last one is still in the lanes.
// Reset restores noise defaults, zero estimates and unit variances.
// A stalled output holds the lanes in their done state.
module kalman_pose_smoother_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  kps_stream_if.sink   meas_i,
  kps_stream_if.sink   cfg_i,
  kps_stream_if.source est_o
);

  logic [kps_pkg::NoiseW-1:0] q_q, q_d;
  logic [kps_pkg::NoiseW-1:0] r_q, r_d;
  logic                       busy_q, busy_d;
  logic                       accept;
  logic                       ack;

  kps_pkg::lane_ctrl_t                      ctrl;
  kps_pkg::lane_stat_t [kps_pkg::AXES-1:0]  stat;
  logic [kps_pkg::AXES-1:0][kps_pkg::DataW-1:0] z;

  assign cfg_i.ready  = 1'b1;
  assign meas_i.ready = !busy_q;
  assign accept       = meas_i.valid && !busy_q;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        kps_pkg::CFG_PROCESS_NOISE: q_d = cfg_i.data.value[kps_pkg::NoiseW-1:0];
        kps_pkg::CFG_MEAS_NOISE:    r_d = cfg_i.data.value[kps_pkg::NoiseW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (ack) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= kps_pkg::ProcNoiseRst;
      r_q    <= kps_pkg::MeasNoiseRst;
      busy_q <= 1'b0;
    end else begin
      q_q    <= q_d;
      r_q    <= r_d;
      busy_q <= busy_d;
    end
  end

  assign ctrl.start = accept;
  assign ctrl.ack   = ack;

  assign z[0] = meas_i.data.meas_x;
  assign z[1] = meas_i.data.meas_y;
  assign z[2] = meas_i.data.meas_z;
  assign z[3] = meas_i.data.meas_roll;
  assign z[4] = meas_i.data.meas_pitch;
  assign z[5] = meas_i.data.meas_yaw;

  for (genvar a = 0; a < kps_pkg::AXES; a++) begin : g_lane
    kps_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .meas_i (z[a]),
      .q_i    (q_q),
      .r_i    (r_q),
      .stat_o (stat[a])
    );
  end

  kps_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ack_o  (ack),
    .est_o  (est_o)
  );

endmodule
